[rtl/core/ipv6c_pkg.sv]
package ipv6c_pkg;

  localparam int NumGroups = 8;
  localparam int GroupW    = 16;
  localparam int CharW     = 7;
  localparam int IdxW      = $clog2(NumGroups);
  localparam int LenW      = IdxW + 1;

  localparam logic [CharW-1:0] CharColon = 7'h3A;
  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharUpA   = 7'h41;
  localparam logic [CharW-1:0] CharLowA  = 7'h61;

  // controller -> datapath
  typedef struct packed {
    logic            load;        // capture the address groups
    logic            analyze;     // register the zero-run search result
    logic            emit;        // produce one character
    logic            emit_colon;  // character is ':' instead of a digit
    logic            finish;      // flush the held character as the last one
    logic [IdxW-1:0] idx;         // group under work
    logic [1:0]      nib;         // nibble under work, 0 is the most significant
  } ipv6c_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic            at_best;     // current group opens the compressed run
    logic [LenW-1:0] best_len;    // length of the compressed run
    logic [1:0]      lead;        // first nibble to print of the current group
  } ipv6c_sts_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [CharW-1:0] base;
    base = upper ? CharUpA : CharLowA;
    if (nib < 4'd10) begin
      hex_char = CharZero + {3'b000, nib};
    end else begin
      hex_char = base + {3'b000, nib} - 7'd10;
    end
  endfunction

endpackage

[rtl/core/ipv6c_datapath.sv]
module ipv6c_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [ipv6c_pkg::GroupW-1:0]          groups_i [ipv6c_pkg::NumGroups],
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_data_i,
  input  ipv6c_pkg::ipv6c_cmd_t                 cmd_i,
  output ipv6c_pkg::ipv6c_sts_t                 sts_o,
  output logic                                  text_valid_o,
  output logic [ipv6c_pkg::CharW-1:0]           text_char_o,
  output logic                                  last_char_o
);
  import ipv6c_pkg::*;

  logic [GroupW-1:0] grp_q [NumGroups];
  logic              upper_q;
  logic [IdxW-1:0]   best_start_q, best_start_d;
  logic [LenW-1:0]   best_len_q, best_len_d;
  logic              pend_valid_q, pend_valid_d;
  logic [CharW-1:0]  pend_char_q, pend_char_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  logic [NumGroups-1:0] zero;
  logic [LenW-1:0]      run_len [NumGroups];
  logic [GroupW-1:0]    cur_grp;
  logic [3:0]           cur_nib;
  logic [1:0]           lead;
  logic [CharW-1:0]     new_char;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      grp_q <= groups_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 1'b0;
    end else if (cfg_we_i) begin
      upper_q <= cfg_data_i;
    end
  end

  // zero-run length starting at each group
  always_comb begin
    logic cont;
    for (int s = 0; s < NumGroups; s++) begin
      zero[s] = (grp_q[s] == '0);
    end
    for (int s = 0; s < NumGroups; s++) begin
      run_len[s] = '0;
      cont = 1'b1;
      for (int k = s; k < NumGroups; k++) begin
        if (cont && zero[k]) begin
          run_len[s] = run_len[s] + 1'b1;
        end else begin
          cont = 1'b0;
        end
      end
    end
  end

  // leftmost longest run: strict compare keeps the earlier start on ties
  always_comb begin
    best_start_d = '0;
    best_len_d   = '0;
    for (int s = 0; s < NumGroups; s++) begin
      if (run_len[s] > best_len_d) begin
        best_len_d   = run_len[s];
        best_start_d = IdxW'(s);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.analyze) begin
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
    end
  end

  assign cur_grp = grp_q[cmd_i.idx];

  always_comb begin
    case (cmd_i.nib)
      2'd0:    cur_nib = cur_grp[15:12];
      2'd1:    cur_nib = cur_grp[11:8];
      2'd2:    cur_nib = cur_grp[7:4];
      default: cur_nib = cur_grp[3:0];
    endcase
  end

  // a zero group prints its last nibble only, i.e. "0"
  always_comb begin
    if (cur_grp[15:12] != '0) begin
      lead = 2'd0;
    end else if (cur_grp[11:8] != '0) begin
      lead = 2'd1;
    end else if (cur_grp[7:4] != '0) begin
      lead = 2'd2;
    end else begin
      lead = 2'd3;
    end
  end

  assign sts_o.lead     = lead;
  assign sts_o.at_best  = (best_len_q != '0) && (cmd_i.idx == best_start_q);
  assign sts_o.best_len = best_len_q;

  assign new_char = cmd_i.emit_colon ? CharColon : hex_char(cur_nib, upper_q);

  // one character is held back so the last one can be flagged on finish
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_char_d  = pend_char_q;
    out_valid_d  = 1'b0;
    out_char_d   = pend_char_q;
    out_last_d   = 1'b0;
    if (cmd_i.emit) begin
      out_valid_d  = pend_valid_q;
      pend_valid_d = 1'b1;
      pend_char_d  = new_char;
    end else if (cmd_i.finish) begin
      out_valid_d  = pend_valid_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_char_q <= pend_char_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
  end

  assign text_valid_o = out_valid_q;
  assign text_char_o  = out_char_q;
  assign last_char_o  = out_last_q;

endmodule

[rtl/core/ipv6c_ctrl.sv]
module ipv6c_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  ipv6c_pkg::ipv6c_sts_t sts_i,
  output ipv6c_pkg::ipv6c_cmd_t cmd_o
);
  import ipv6c_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StAnalyze = 3'd1;
  localparam logic [2:0] StGroup   = 3'd2;
  localparam logic [2:0] StDigits  = 3'd3;
  localparam logic [2:0] StDColon  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [1:0]      nib_q, nib_d;
  logic            need_colon_q, need_colon_d;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    nib_d        = nib_q;
    need_colon_d = need_colon_q;
    cmd_o            = '0;
    cmd_o.idx        = idx_q[IdxW-1:0];
    cmd_o.nib        = nib_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StAnalyze;
        end
      end
      StAnalyze: begin
        cmd_o.analyze = 1'b1;
        idx_d         = '0;
        need_colon_d  = 1'b0;
        state_d       = StGroup;
      end
      StGroup: begin
        if (idx_q >= LenW'(NumGroups)) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else if (sts_i.at_best) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_colon = 1'b1;
          state_d          = StDColon;
        end else begin
          if (need_colon_q) begin
            cmd_o.emit       = 1'b1;
            cmd_o.emit_colon = 1'b1;
          end
          nib_d   = sts_i.lead;
          state_d = StDigits;
        end
      end
      StDigits: begin
        cmd_o.emit = 1'b1;
        if (nib_q == 2'd3) begin
          idx_d        = idx_q + 1'b1;
          need_colon_d = 1'b1;
          state_d      = StGroup;
        end else begin
          nib_d = nib_q + 1'b1;
        end
      end
      StDColon: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_colon = 1'b1;
        idx_d            = idx_q + sts_i.best_len;
        need_colon_d     = 1'b0;
        state_d          = StGroup;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      idx_q        <= '0;
      nib_q        <= '0;
      need_colon_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      nib_q        <= nib_d;
      need_colon_q <= need_colon_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

[rtl/core/ipv6_address_compressor_core.sv]
// IPv6 address text compressor.
// Command side: raise start with group_0_i..group_7_i (group_0 leftmost);
// the address is taken at a clock edge where start is high and busy is low.
// Result side: one ASCII character per transaction, marked by text_valid_o
// for exactly one cycle; last_char_o flags the final character. The
// receiver cannot stall the block, so it must take every strobe.
// Config side: cfg_valid_i/cfg_ready_o write cfg_data_i into the
// letter-case register (1 = A-F, 0 = a-f). Write it only while idle.
// Sequence: a text is 2..39 characters long; busy stays high while the
// block finds the zero run, emits each character and runs a flush step,
// plus an empty step before the first group when the text does not open
// with "::" and one after "::" when groups follow it. The last character
// appears in the first cycle with busy low, when the next address may
// already be taken.
// Reset: asynchronous, active low; clears the sequencer, the output strobe
// and the letter-case register (lowercase).
module ipv6_address_compressor_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ipv6c_pkg::GroupW-1:0]        group_0_i,
  input  logic [ipv6c_pkg::GroupW-1:0]        group_1_i,
  input  logic [ipv6c_pkg::GroupW-1:0]        group_2_i,
  input  logic [ipv6c_pkg::GroupW-1:0]        group_3_i,
  input  logic [ipv6c_pkg::GroupW-1:0]        group_4_i,
  input  logic [ipv6c_pkg::GroupW-1:0]        group_5_i,
  input  logic [ipv6c_pkg::GroupW-1:0]        group_6_i,
  input  logic [ipv6c_pkg::GroupW-1:0]        group_7_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_data_i,
  output logic                                text_valid_o,
  output logic [ipv6c_pkg::CharW-1:0]         text_char_o,
  output logic                                last_char_o
);
  import ipv6c_pkg::*;

  logic [GroupW-1:0] groups [NumGroups];
  ipv6c_cmd_t        cmd;
  ipv6c_sts_t        sts;

  assign groups[0] = group_0_i;
  assign groups[1] = group_1_i;
  assign groups[2] = group_2_i;
  assign groups[3] = group_3_i;
  assign groups[4] = group_4_i;
  assign groups[5] = group_5_i;
  assign groups[6] = group_6_i;
  assign groups[7] = group_7_i;

  // register write is always taken; caller keeps it to idle periods
  assign cfg_ready_o = 1'b1;

  ipv6c_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  ipv6c_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .groups_i     (groups),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .text_valid_o (text_valid_o),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

endmodule
